@@ design/ticket_queue_with_keyed_removal_top_macros.svh @@
// Assertion macros used by the checker file of the ticket queue.
// Both expect i_clk and i_rst_n to be visible where they are used.
`ifndef TICKET_QUEUE_WITH_KEYED_REMOVAL_TOP_MACROS_SVH
`define TICKET_QUEUE_WITH_KEYED_REMOVAL_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TQKR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tqkr: same-cycle property failed");

// Consequent checked in the cycle after the antecedent.
`define TQKR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tqkr: next-cycle property failed");

`endif

@@ design/tqkr_pkg.sv @@
package tqkr_pkg;

    // Default number of entries in the queue.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Fixed field widths.
    localparam int TICKET_W = 16;
    localparam int NAME_W   = 64;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Ticket numbers run from one to all ones and then start over at one.
    localparam logic [TICKET_W-1:0] TICKET_FIRST = TICKET_W'(1);
    localparam logic [TICKET_W-1:0] TICKET_LAST  = '1;

    // Operation codes carried on the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ       = 2'd0,
        FUNC_FRONT     = 2'd1,
        FUNC_BY_TICKET = 2'd2,
        FUNC_NONE      = 2'd3
    } t_func;

    // Status codes carried on the output tuser.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic enq;    // store the new entry at the tail cell
        logic start;  // place the search token on the first cell
        logic adv;    // move the token one cell down the chain
        logic found;  // the entry has been taken, later cells move up
        logic any;    // every live cell matches (serve front)
    } t_cell_ctl;

endpackage

@@ design/tqkr_cell.sv @@
module tqkr_cell import tqkr_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic [CNT_W-1:0]    i_occ,
    input  logic [TICKET_W-1:0] i_target,
    input  logic [TICKET_W-1:0] i_new_ticket,
    input  logic [NAME_W-1:0]   i_new_name,
    input  logic                i_tok_prev,
    input  logic                i_tok_next,
    input  logic [TICKET_W-1:0] i_nxt_ticket,
    input  logic [NAME_W-1:0]   i_nxt_name,
    output logic [TICKET_W-1:0] o_ticket,
    output logic [NAME_W-1:0]   o_name,
    output logic                o_tok,
    output logic                o_live,
    output logic                o_hit
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [TICKET_W-1:0] r_ticket;
    logic [NAME_W-1:0]   r_name;
    logic                r_tok;
    logic                n_tok;

    // This cell holds an entry of the queue when it lies below the count.
    assign o_live = (IDX_C < i_occ);

    // Match seen while the token sits here.
    assign o_hit = r_tok && o_live && (i_ctl.any || (r_ticket == i_target));

    // Token either starts on the first cell or is handed on from the left.
    always_comb begin
        if (i_ctl.start) begin
            n_tok = (IDX == 0);
        end else if (i_ctl.adv) begin
            n_tok = i_tok_prev;
        end else begin
            n_tok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Entry store: written at the tail, or taken from the right-hand neighbour
    // once the token has passed the removed entry.
    always_ff @(posedge i_clk) begin
        if (i_ctl.enq && (IDX_C == i_occ)) begin
            r_ticket <= i_new_ticket;
            r_name   <= i_new_name;
        end else if (i_ctl.found && i_tok_next) begin
            r_ticket <= i_nxt_ticket;
            r_name   <= i_nxt_name;
        end
    end

    assign o_ticket = r_ticket;
    assign o_name   = r_name;
    assign o_tok    = r_tok;

endmodule

@@ design/ticket_queue_with_keyed_removal_top.sv @@
// Ordered ticket queue with removal by key, built as a chain of entry cells.
// Input channel (s side): tuser carries the operation (enqueue, serve front,
// serve by ticket); tdata carries the name tag and the ticket to serve.
// Output channel (m side): one result beat per input beat, tuser carries the
// status, tdata the ticket, the served name and the entries left.
// Enqueue, the unused operation and a serve on an empty queue give their
// result in the cycle after the input beat is taken.
// A serve on a non-empty queue sends a token down the cell chain, one cell
// a cycle; later cells move up one place behind the token, so search and
// compaction finish in the same pass.
// One operation is in flight at a time; s_tready is low while a serve walks
// the chain. A finished result waits in the output register while m_tready
// is low, and no new beat is taken until that register is free or emptying.
// Reset empties the queue, restarts ticket numbers at one and drops any
// pending result.
module ticket_queue_with_keyed_removal_top import tqkr_pkg::*; #(
    parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W        = NAME_W + TICKET_W,
    localparam int OUT_W       = ((TICKET_W + NAME_W + CNT_W + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [IN_W-1:0]     i_s_tdata,   // name_tag, target_ticket
    input  logic [FUNC_W-1:0]   i_s_tuser,   // func
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [OUT_W-1:0]    o_m_tdata,   // ticket, served_name, remaining, zero pad
    output logic [STATUS_W-1:0] o_m_tuser    // status
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_occ;
    logic [TICKET_W-1:0] r_next;
    logic                r_found;
    logic                r_any;
    logic [TICKET_W-1:0] r_target;
    logic [TICKET_W-1:0] r_cap_ticket;
    logic [NAME_W-1:0]   r_cap_name;

    logic                r_out_valid;
    t_status             r_res_status;
    logic [TICKET_W-1:0] r_res_ticket;
    logic [NAME_W-1:0]   r_res_name;
    logic [CNT_W-1:0]    r_res_remaining;

    logic                w_accept;
    t_func               w_func;
    logic [NAME_W-1:0]   w_in_name;
    logic [TICKET_W-1:0] w_in_target;
    logic                w_full;
    logic                w_tok_live;
    logic                w_any_hit;
    logic [TICKET_W-1:0] w_hit_ticket;
    logic [NAME_W-1:0]   w_hit_name;
    logic [CNT_W-1:0]    w_after_serve;
    t_cell_ctl           w_ctl;

    logic [TICKET_W-1:0] w_ticket [QUEUE_DEPTH];
    logic [NAME_W-1:0]   w_name   [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_tok;
    logic [QUEUE_DEPTH-1:0] w_live;
    logic [QUEUE_DEPTH-1:0] w_hit;

    // Input unpacking and handshake.
    assign w_in_name   = i_s_tdata[NAME_W-1:0];
    assign w_in_target = i_s_tdata[NAME_W +: TICKET_W];
    assign w_func      = t_func'(i_s_tuser);
    assign o_s_tready  = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_full      = (r_occ >= CNT_W'(QUEUE_DEPTH));

    // Cell controls.
    always_comb begin
        w_ctl.enq   = (r_state == S_IDLE) && w_accept && (w_func == FUNC_ENQ) && !w_full;
        w_ctl.start = (r_state == S_IDLE) && w_accept && (r_occ != '0) &&
                      ((w_func == FUNC_FRONT) || (w_func == FUNC_BY_TICKET));
        w_ctl.adv   = (r_state == S_SCAN) && w_tok_live;
        w_ctl.found = r_found;
        w_ctl.any   = r_any;
    end

    // The chain of entry cells.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        logic                w_tok_prev;
        logic                w_tok_next;
        logic [TICKET_W-1:0] w_nxt_ticket;
        logic [NAME_W-1:0]   w_nxt_name;

        if (gi == 0) begin : g_first
            assign w_tok_prev = 1'b0;
        end else begin : g_mid
            assign w_tok_prev = w_tok[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_tok_next   = 1'b0;
            assign w_nxt_ticket = '0;
            assign w_nxt_name   = '0;
        end else begin : g_inner
            assign w_tok_next   = w_tok[gi+1];
            assign w_nxt_ticket = w_ticket[gi+1];
            assign w_nxt_name   = w_name[gi+1];
        end

        tqkr_cell #(
            .IDX   (gi),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_occ        (r_occ),
            .i_target     (r_target),
            .i_new_ticket (r_next),
            .i_new_name   (w_in_name),
            .i_tok_prev   (w_tok_prev),
            .i_tok_next   (w_tok_next),
            .i_nxt_ticket (w_nxt_ticket),
            .i_nxt_name   (w_nxt_name),
            .o_ticket     (w_ticket[gi]),
            .o_name       (w_name[gi]),
            .o_tok        (w_tok[gi]),
            .o_live       (w_live[gi]),
            .o_hit        (w_hit[gi])
        );
    end

    // At most one cell holds the token, so an OR of the gated entries
    // picks out the matching one.
    always_comb begin
        w_hit_ticket = '0;
        w_hit_name   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (w_hit[i]) begin
                w_hit_ticket = w_hit_ticket | w_ticket[i];
                w_hit_name   = w_hit_name | w_name[i];
            end
        end
    end

    assign w_tok_live    = |(w_tok & w_live);
    assign w_any_hit     = |w_hit;
    assign w_after_serve = r_occ - CNT_W'(r_found);

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_next      <= TICKET_FIRST;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (w_func)
                            FUNC_ENQ: begin
                                r_out_valid <= 1'b1;
                                r_res_name  <= '0;
                                if (w_full) begin
                                    r_res_status    <= ST_FULL;
                                    r_res_ticket    <= '0;
                                    r_res_remaining <= r_occ;
                                end else begin
                                    r_res_status    <= ST_OK;
                                    r_res_ticket    <= r_next;
                                    r_res_remaining <= r_occ + CNT_W'(1);
                                    r_occ           <= r_occ + CNT_W'(1);
                                    r_next <= (r_next == TICKET_LAST) ? TICKET_FIRST
                                                                      : r_next + TICKET_W'(1);
                                end
                            end
                            FUNC_FRONT, FUNC_BY_TICKET: begin
                                if (r_occ == '0) begin
                                    r_out_valid     <= 1'b1;
                                    r_res_status    <= ST_EMPTY;
                                    r_res_ticket    <= '0;
                                    r_res_name      <= '0;
                                    r_res_remaining <= r_occ;
                                end else begin
                                    r_state  <= S_SCAN;
                                    r_found  <= 1'b0;
                                    r_any    <= (w_func == FUNC_FRONT);
                                    r_target <= w_in_target;
                                end
                            end
                            default: begin
                                r_out_valid     <= 1'b1;
                                r_res_status    <= ST_OK;
                                r_res_ticket    <= '0;
                                r_res_name      <= '0;
                                r_res_remaining <= r_occ;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_tok_live) begin
                        // Keep the oldest match; later cells then move up.
                        if (!r_found && w_any_hit) begin
                            r_found      <= 1'b1;
                            r_cap_ticket <= w_hit_ticket;
                            r_cap_name   <= w_hit_name;
                        end
                    end else begin
                        // Token has left the live part of the chain.
                        r_state         <= S_IDLE;
                        r_out_valid     <= 1'b1;
                        r_res_status    <= r_found ? ST_OK : ST_NOT_FOUND;
                        r_res_ticket    <= r_found ? r_cap_ticket : '0;
                        r_res_name      <= r_found ? r_cap_name : '0;
                        r_res_remaining <= w_after_serve;
                        r_occ           <= w_after_serve;
                        r_found         <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output packing.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_res_status;
    assign o_m_tdata  = OUT_W'({r_res_remaining, r_res_name, r_res_ticket});

endmodule

@@ design/tqkr_checker.sv @@
`include "ticket_queue_with_keyed_removal_top_macros.svh"

module tqkr_checker import tqkr_pkg::*; #(
    parameter  int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    localparam int OUT_W       = ((TICKET_W + NAME_W + CNT_W + 7) / 8) * 8
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [OUT_W-1:0]    o_m_tdata,
    input logic [STATUS_W-1:0] o_m_tuser
);

    logic [TICKET_W-1:0] w_ticket;
    logic [NAME_W-1:0]   w_name;
    logic [CNT_W-1:0]    w_remaining;

    assign w_ticket    = o_m_tdata[TICKET_W-1:0];
    assign w_name      = o_m_tdata[TICKET_W +: NAME_W];
    assign w_remaining = o_m_tdata[TICKET_W + NAME_W +: CNT_W];

    // A stalled result beat stays put.
    `TQKR_ASSERT_NEXT(a_hold_stalled, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

    // Error results carry no ticket and no name.
    `TQKR_ASSERT_SAME(a_error_clean, o_m_tvalid && (o_m_tuser != ST_OK), (w_ticket == '0) && (w_name == '0))

    // The count never passes the queue depth.
    `TQKR_ASSERT_SAME(a_count_bound, o_m_tvalid, w_remaining <= CNT_W'(QUEUE_DEPTH))

    // A refused enqueue means the queue really is full.
    `TQKR_ASSERT_SAME(a_full_count, o_m_tvalid && (o_m_tuser == ST_FULL), w_remaining == CNT_W'(QUEUE_DEPTH))

    // An empty report means no entries remain.
    `TQKR_ASSERT_SAME(a_empty_count, o_m_tvalid && (o_m_tuser == ST_EMPTY), w_remaining == '0)

endmodule

bind ticket_queue_with_keyed_removal_top tqkr_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tqkr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
